// ===== hw/rtl/gpio_port_register_block_core_defines.svh =====
// Assertion macros shared by the GPIO port RTL.
`ifndef GPIO_PORT_REGISTER_BLOCK_CORE_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPIOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPIOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gpioc_pkg.sv =====
package gpioc_pkg;

    localparam int GPIOC_PIN_COUNT = 16;
    localparam int GPIOC_MAX_PINS  = 16;
    localparam int GPIOC_KEY_BIT   = 16;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0] IDX_MODE     = 4'd0;
    localparam logic [3:0] IDX_OTYPE    = 4'd1;
    localparam logic [3:0] IDX_SPEED    = 4'd2;
    localparam logic [3:0] IDX_PULL     = 4'd3;
    localparam logic [3:0] IDX_INPUT    = 4'd4;
    localparam logic [3:0] IDX_OUTPUT   = 4'd5;
    localparam logic [3:0] IDX_SETRESET = 4'd6;
    localparam logic [3:0] IDX_LOCK     = 4'd7;
    localparam logic [3:0] IDX_AFRL     = 4'd8;
    localparam logic [3:0] IDX_AFRH     = 4'd9;

    typedef struct packed {
        logic        command;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pad_levels;
    } gpioc_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pad_drive;
        logic        port_locked;
        logic        bad_index;
    } gpioc_rsp_t;

    typedef enum logic [1:0] {
        LOCK_IDLE  = 2'd0,
        LOCK_KEY1  = 2'd1,
        LOCK_KEY0  = 2'd2,
        LOCK_ARMED = 2'd3
    } lock_step_t;

    // One lock register access, applied in the cycle it is valid.
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic        key;
        logic [15:0] data_mask;
    } lock_req_t;

    typedef struct packed {
        logic        done;
        logic        key_bit;
        logic [15:0] mask;
    } lock_status_t;

    // Pins that exist on this port; the count is clamped to 1..16.
    function automatic logic [15:0] gpioc_pins_present(input int count);
        int          n;
        logic [15:0] m;
        n = count;
        if (n > GPIOC_MAX_PINS) n = GPIOC_MAX_PINS;
        if (n < 1) n = 1;
        for (int i = 0; i < GPIOC_MAX_PINS; i++) begin
            m[i] = (i < n);
        end
        return m;
    endfunction

    // Widen each pin bit to its 2-bit field.
    function automatic logic [31:0] gpioc_spread2(input logic [15:0] m);
        logic [31:0] r;
        for (int i = 0; i < 16; i++) begin
            r[2*i +: 2] = {2{m[i]}};
        end
        return r;
    endfunction

    // Widen each pin bit to its 4-bit field.
    function automatic logic [31:0] gpioc_spread4(input logic [7:0] m);
        logic [31:0] r;
        for (int i = 0; i < 8; i++) begin
            r[4*i +: 4] = {4{m[i]}};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/gpioc_lock.sv =====
`include "gpio_port_register_block_core_defines.svh"

module gpioc_lock
    import gpioc_pkg::*;
#(
    parameter int PIN_COUNT = GPIOC_PIN_COUNT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  lock_req_t    lock_req,
    output lock_status_t lock_cur,
    output lock_status_t lock_nxt
);

    localparam logic [15:0] PRESENT = gpioc_pins_present(PIN_COUNT);

    lock_step_t  step_reg, step_next;
    logic        done_reg, done_next;
    logic        key_reg, key_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] wr_mask;
    logic        same;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg <= LOCK_IDLE;
            done_reg <= 1'b0;
            key_reg  <= 1'b0;
            mask_reg <= '0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
            key_reg  <= key_next;
            mask_reg <= mask_next;
        end
    end

    assign wr_mask = lock_req.data_mask & PRESENT;
    assign same    = (wr_mask == mask_reg);

    always_comb begin
        step_next = step_reg;
        done_next = done_reg;
        key_next  = key_reg;
        mask_next = mask_reg;
        priority if (lock_req.rd && !done_reg && step_reg == LOCK_ARMED) begin
            done_next = 1'b1;
            key_next  = 1'b1;
            step_next = LOCK_IDLE;
        end else if (lock_req.wr && !done_reg) begin
            mask_next = wr_mask;
            key_next  = lock_req.key;
            priority if (step_reg == LOCK_KEY1 && !lock_req.key && same) begin
                step_next = LOCK_KEY0;
            end else if (step_reg == LOCK_KEY0 && lock_req.key && same) begin
                step_next = LOCK_ARMED;
            end else begin
                // broken sequence: restart on a key-1 write, else drop to idle
                step_next = lock_req.key ? LOCK_KEY1 : LOCK_IDLE;
            end
        end
    end

    assign lock_cur = '{done: done_reg, key_bit: key_reg, mask: mask_reg};
    assign lock_nxt = '{done: done_next, key_bit: key_next, mask: mask_next};

    `GPIOC_ASSERT_NEXT(a_lock_sticky, done_reg, done_reg, "lock released before reset")
    `GPIOC_ASSERT_NEXT(a_mask_frozen, done_reg, $stable(mask_reg), "lock mask changed while locked")
    `GPIOC_ASSERT_NOW(a_idle_locked, done_reg, step_reg == LOCK_IDLE && key_reg,
        "key sequence active while locked")

endmodule

// ===== hw/rtl/gpioc_regs.sv =====
`include "gpio_port_register_block_core_defines.svh"

module gpioc_regs
    import gpioc_pkg::*;
#(
    parameter int PIN_COUNT = GPIOC_PIN_COUNT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         apply,
    input  gpioc_req_t   req,
    input  lock_status_t lock_cur,
    input  lock_status_t lock_nxt,
    output gpioc_rsp_t   rsp
);

    localparam logic [15:0] PRESENT = gpioc_pins_present(PIN_COUNT);

    logic [31:0] mode_reg, mode_next;
    logic [15:0] otype_reg, otype_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] pull_reg, pull_next;
    logic [15:0] output_reg, output_next;
    logic [31:0] afrl_reg, afrl_next;
    logic [31:0] afrh_reg, afrh_next;

    logic [15:0] open1;
    logic [31:0] wm2, wm4l, wm4h, data;
    logic [31:0] rd;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg   <= '0;
            otype_reg  <= '0;
            speed_reg  <= '0;
            pull_reg   <= '0;
            output_reg <= '0;
            afrl_reg   <= '0;
            afrh_reg   <= '0;
        end else if (apply) begin
            mode_reg   <= mode_next;
            otype_reg  <= otype_next;
            speed_reg  <= speed_next;
            pull_reg   <= pull_next;
            output_reg <= output_next;
            afrl_reg   <= afrl_next;
            afrh_reg   <= afrh_next;
        end
    end

    // locked pins keep their configuration fields
    assign open1 = PRESENT & ~(lock_cur.done ? lock_cur.mask : 16'h0000);
    assign wm2   = gpioc_spread2(open1);
    assign wm4l  = gpioc_spread4(open1[7:0]);
    assign wm4h  = gpioc_spread4(open1[15:8]);
    assign data  = req.write_data;

    always_comb begin
        mode_next   = mode_reg;
        otype_next  = otype_reg;
        speed_next  = speed_reg;
        pull_next   = pull_reg;
        output_next = output_reg;
        afrl_next   = afrl_reg;
        afrh_next   = afrh_reg;
        if (req.command == CMD_WRITE) begin
            unique case (req.reg_index)
                IDX_MODE:     mode_next  = (mode_reg & ~wm2) | (data & wm2);
                IDX_OTYPE:    otype_next = (otype_reg & ~open1) | (data[15:0] & open1);
                IDX_SPEED:    speed_next = (speed_reg & ~wm2) | (data & wm2);
                IDX_PULL:     pull_next  = (pull_reg & ~wm2) | (data & wm2);
                IDX_OUTPUT:   output_next = data[15:0] & PRESENT;
                // set wins over reset on the same pin
                IDX_SETRESET: output_next = ((output_reg & ~data[31:16]) | data[15:0])
                                            & PRESENT;
                IDX_AFRL:     afrl_next  = (afrl_reg & ~wm4l) | (data & wm4l);
                IDX_AFRH:     afrh_next  = (afrh_reg & ~wm4h) | (data & wm4h);
                default:      ;
            endcase
        end
    end

    always_comb begin
        rd = '0;
        if (req.command == CMD_READ) begin
            unique case (req.reg_index)
                IDX_MODE:   rd = mode_reg;
                IDX_OTYPE:  rd = {16'h0000, otype_reg};
                IDX_SPEED:  rd = speed_reg;
                IDX_PULL:   rd = pull_reg;
                IDX_INPUT:  rd = {16'h0000, req.pad_levels & PRESENT};
                IDX_OUTPUT: rd = {16'h0000, output_reg};
                IDX_LOCK:   rd = {15'h0000, lock_nxt.key_bit, lock_nxt.mask};
                IDX_AFRL:   rd = afrl_reg;
                IDX_AFRH:   rd = afrh_reg;
                default:    rd = '0;
            endcase
        end
    end

    assign rsp.read_data   = rd;
    assign rsp.pad_drive   = output_next;
    assign rsp.port_locked = lock_nxt.done;
    assign rsp.bad_index   = (req.reg_index > IDX_AFRH);

    `GPIOC_ASSERT_NOW(a_absent_pins, 1'b1, (output_reg & ~PRESENT) == 16'h0000,
        "output bit set on an absent pin")

endmodule

// ===== hw/rtl/gpio_port_register_block_core.sv =====
// GPIO port register block: one bus access per item.
// req channel: req carries command, reg_index, write_data and the current
//   pad levels; accepted when req_valid is high and req_stall is low.
// rsp channel: one item per access with read_data, pad_drive (output data
//   after the access), port_locked and bad_index; taken when rsp_valid is
//   high and rsp_stall is low.
// rsp_valid rises once the accepted access has passed an input register,
//   then one pass of mask-and-select logic into the result register.
// Throughput is one access per cycle unless rsp_stall holds; the register file
//   and lock sequencer update in the same cycle the access enters the result register.
// While rsp_stall holds, the result register and the input register keep
//   their items and req_stall rises once both are full.
// Reset clears every port register, the lock sequencer and both valid
//   flags; the port comes up unlocked with all outputs low.
// The lock key sequence (key 1, key 0, key 1 with one mask, then a read of
//   the lock register) freezes mode, otype, speed, pull and alternate
//   function fields of the masked pins until the next reset.
`include "gpio_port_register_block_core_defines.svh"

module gpio_port_register_block_core
    import gpioc_pkg::*;
#(
    parameter int PIN_COUNT = GPIOC_PIN_COUNT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  gpioc_req_t req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output gpioc_rsp_t rsp
);

    logic         req_valid_reg;
    gpioc_req_t   req_reg;
    logic         rsp_valid_reg;
    gpioc_rsp_t   rsp_reg;
    gpioc_rsp_t   rsp_next;
    logic         advance;
    logic         apply;
    lock_req_t    lock_req;
    lock_status_t lock_cur;
    lock_status_t lock_nxt;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign apply     = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (!req_stall) req_valid_reg <= req_valid;
            if (advance) rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (req_valid && !req_stall) req_reg <= req;
        if (apply) rsp_reg <= rsp_next;
    end

    assign lock_req.rd        = apply && req_reg.command == CMD_READ
                                && req_reg.reg_index == IDX_LOCK;
    assign lock_req.wr        = apply && req_reg.command == CMD_WRITE
                                && req_reg.reg_index == IDX_LOCK;
    assign lock_req.key       = req_reg.write_data[GPIOC_KEY_BIT];
    assign lock_req.data_mask = req_reg.write_data[15:0];

    gpioc_lock #(
        .PIN_COUNT (PIN_COUNT)
    ) u_lock (
        .clk      (clk),
        .rst_n    (rst_n),
        .lock_req (lock_req),
        .lock_cur (lock_cur),
        .lock_nxt (lock_nxt)
    );

    gpioc_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .apply    (apply),
        .req      (req_reg),
        .lock_cur (lock_cur),
        .lock_nxt (lock_nxt),
        .rsp      (rsp_next)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `GPIOC_ASSERT_NOW(a_stall_full, req_stall, req_valid_reg && rsp_valid_reg,
        "input stalled with a free stage")
    `GPIOC_ASSERT_NEXT(a_apply_delivers, apply, rsp_valid_reg,
        "processed item did not reach the result register")

endmodule
